FILE: rtl/assert_macros.svh
// assertion macros shared by the polarity index rtl
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication under active-low reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication under active-low reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/depi_pkg.sv
// shared types and constants of the dual moving average polarity index
// no dependencies
package depi_pkg;

    // default widths of the top level
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int LEVEL_WIDTH_DEF  = 24;
    localparam int COUNT_WIDTH_DEF  = 32;

    // fixed formats
    localparam int ALPHA_W   = 16;
    localparam int INDEX_W   = 16;
    localparam int EXTREME_W = 15;
    localparam int QUOT_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(QUOT_W);

    localparam logic [ALPHA_W:0]        ALPHA_ONE = 17'h10000;
    localparam logic [INDEX_W-1:0]      INDEX_MAX = 16'h7FFF;
    localparam logic [QUOT_W-1:0]       QUOT_LIMIT = 16'h8000;
    localparam logic [DIV_CNT_W-1:0]    DIV_LAST = DIV_CNT_W'(QUOT_W - 1);
    localparam logic [1:0]              MUL_LAST = 2'd3;

    // register reset values
    localparam logic [ALPHA_W-1:0]   SMOOTH_RST  = 16'd6554;
    localparam logic [ALPHA_W-1:0]   WARMUP_RST  = 16'd10;
    localparam logic [EXTREME_W-1:0] EXTREME_RST = 15'd26214;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTREME   = 2'd2;

    // command codes of the input word
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SETUP,
        ST_DIV,
        ST_FINISH
    } depi_state_t;

    // divider control and status
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/depi_divider.sv
// restoring divider, one quotient bit per cycle, for the index ratio
// depends on depi_pkg and assert_macros.svh
`include "assert_macros.svh"

module depi_divider #(
    parameter int LEVEL_WIDTH = depi_pkg::LEVEL_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  depi_pkg::div_ctrl_t         ctrl,
    input  logic [LEVEL_WIDTH-1:0]      num,
    input  logic [LEVEL_WIDTH:0]        den,
    output depi_pkg::div_stat_t         stat,
    output logic [depi_pkg::QUOT_W-1:0] quot
);
    import depi_pkg::*;

    localparam int REM_W   = LEVEL_WIDTH + 1;
    localparam int TRIAL_W = LEVEL_WIDTH + 2;

    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [REM_W-1:0]     den_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 first_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [TRIAL_W-1:0]   trial;
    logic [TRIAL_W-1:0]   trial_diff;
    logic                 fits;

    // first step compares the numerator as is, later steps shift in a zero
    always_comb
    begin
        trial      = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        trial_diff = trial - {1'b0, den_reg};
        fits       = (trial >= {1'b0, den_reg});
        rem_next   = fits ? REM_W'(trial_diff) : REM_W'(trial);
    end

    // step counter and busy/done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            first_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (busy_reg)
        begin
            first_reg <= 1'b0;
            cnt_reg   <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

    `ASSERT_IMPLIES(a_no_restart, clk, rst_n, busy_reg, !ctrl.start)
    `ASSERT_NEXT(a_start_busy, clk, rst_n, ctrl.start, busy_reg && !done_reg)
    `ASSERT_IMPLIES(a_quot_bound, clk, rst_n, done_reg && (den_reg != '0), quot_reg <= QUOT_LIMIT)

endmodule

FILE: rtl/dual_ema_polarity_index_top.sv
// dual moving average polarity index, top level; depends on depi_pkg, depi_divider
// a sample word passes through the shared multiplier steps, a setup step, the restoring divider
// and the finish step before its result word is registered; a clear word goes straight to the
// finish step; one word at a time: no new word is taken until the last one's result word
// is registered, and the finish step waits while a held result word is stalled
// reset: async active low, clears averages, index, counters, result valid; config to defaults
`include "assert_macros.svh"

module dual_ema_polarity_index_top #(
    parameter int SAMPLE_WIDTH = depi_pkg::SAMPLE_WIDTH_DEF,
    parameter int LEVEL_WIDTH  = depi_pkg::LEVEL_WIDTH_DEF,
    parameter int COUNT_WIDTH  = depi_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [depi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [depi_pkg::ALPHA_W-1:0]        cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic signed [SAMPLE_WIDTH-1:0]      bias,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [depi_pkg::INDEX_W-1:0] polarity_index,
    output logic signed [depi_pkg::INDEX_W-1:0] previous_index,
    output logic                                flip_event,
    output logic                                extreme_event,
    output logic [LEVEL_WIDTH-1:0]              bull_average,
    output logic [LEVEL_WIDTH-1:0]              bear_average,
    output logic [COUNT_WIDTH-1:0]              flip_total,
    output logic [COUNT_WIDTH-1:0]              extreme_total,
    output logic [COUNT_WIDTH-1:0]              sample_total
);
    import depi_pkg::*;

    localparam int LW      = LEVEL_WIDTH;
    localparam int SW      = SAMPLE_WIDTH;
    localparam int PROD_W  = LW + ALPHA_W + 1;
    localparam int ACC_W   = PROD_W + 1;
    localparam int CMP_W   = (COUNT_WIDTH > ALPHA_W) ? COUNT_WIDTH : ALPHA_W;
    localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << (LW - 1);

    // configuration registers
    logic [ALPHA_W-1:0]   smooth_reg;
    logic [ALPHA_W-1:0]   warmup_reg;
    logic [EXTREME_W-1:0] extreme_reg;

    // block state
    depi_state_t          state_reg;
    depi_state_t          state_next;
    logic [LW-1:0]        bull_level_reg;
    logic [LW-1:0]        bear_level_reg;
    logic [INDEX_W-1:0]   last_index_reg;
    logic                 seeded_reg;
    logic [COUNT_WIDTH-1:0] flip_cnt_reg;
    logic [COUNT_WIDTH-1:0] extreme_cnt_reg;
    logic [COUNT_WIDTH-1:0] sample_cnt_reg;
    logic [COUNT_WIDTH-1:0] flip_cnt_next;
    logic [COUNT_WIDTH-1:0] extreme_cnt_next;
    logic [COUNT_WIDTH-1:0] sample_cnt_next;

    // per-word working registers
    logic                 clear_reg;
    logic                 fed_bull_reg;
    logic [LW-1:0]        feed_reg;
    logic [1:0]           mul_cnt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    acc_reg;

    // result register
    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   index_out_reg;
    logic [INDEX_W-1:0]   prev_out_reg;
    logic                 flip_out_reg;
    logic                 extreme_out_reg;
    logic [LW-1:0]        bull_out_reg;
    logic [LW-1:0]        bear_out_reg;
    logic [COUNT_WIDTH-1:0] flip_out_cnt_reg;
    logic [COUNT_WIDTH-1:0] extreme_out_cnt_reg;
    logic [COUNT_WIDTH-1:0] sample_out_cnt_reg;

    // combinational helpers
    logic                 in_take;
    logic                 finish_go;
    logic [SW-1:0]        bias_u;
    logic                 bias_pos;
    logic [SW-1:0]        mag;
    logic [LW-1:0]        feed_w;
    logic [ALPHA_W:0]     alpha_c;
    logic [LW-1:0]        fed_lvl;
    logic [LW-1:0]        oth_lvl;
    logic [LW-1:0]        mul_a;
    logic [ALPHA_W:0]     mul_b;
    logic [PROD_W-1:0]    prod_w;
    logic [ACC_W-1:0]     acc_sum;
    logic [LW-1:0]        fed_new;
    logic [LW-1:0]        oth_new;
    logic                 bull_ge;
    logic [LW:0]          div_sum;
    logic [LW-1:0]        div_diff;
    logic                 sum_zero;
    logic [QUOT_W-1:0]    quot;
    logic [INDEX_W-1:0]   idx_new;
    logic [INDEX_W-1:0]   idx_mag;
    logic                 gate;
    logic                 flip_now;
    logic                 extreme_now;
    div_ctrl_t            div_ctrl;
    div_stat_t            div_stat;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg  <= SMOOTH_RST;
            warmup_reg  <= WARMUP_RST;
            extreme_reg <= EXTREME_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SMOOTHING: smooth_reg  <= cfg_data;
                REG_WARMUP:    warmup_reg  <= cfg_data;
                REG_EXTREME:   extreme_reg <= cfg_data[EXTREME_W-1:0];
                default:       ;
            endcase
        end
    end

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // sample magnitude in level format
    assign bias_u   = bias;
    assign bias_pos = !bias_u[SW-1] && (bias_u != '0);
    assign mag      = bias_u[SW-1] ? (~bias_u + 1'b1) : bias_u;

    generate
        if (LW >= SW)
        begin : g_widen
            assign feed_w = LW'(mag) << (LW - SW);
        end
        else
        begin : g_narrow
            assign feed_w = LW'(mag >> (SW - LW));
        end
    endgenerate

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        div_ctrl.start = 1'b0;
        finish_go      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = (command == CMD_CLEAR) ? ST_FINISH : ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_cnt_reg == MUL_LAST)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                div_ctrl.start = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    finish_go  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // shared multiplier operand select
    assign alpha_c = ALPHA_ONE - {1'b0, smooth_reg};
    assign fed_lvl = fed_bull_reg ? bull_level_reg : bear_level_reg;
    assign oth_lvl = fed_bull_reg ? bear_level_reg : bull_level_reg;

    always_comb
    begin
        unique case (mul_cnt_reg)
            2'd0:
            begin
                mul_a = fed_lvl;
                mul_b = alpha_c;
            end
            2'd1:
            begin
                mul_a = feed_reg;
                mul_b = {1'b0, smooth_reg};
            end
            default:
            begin
                mul_a = oth_lvl;
                mul_b = alpha_c;
            end
        endcase
    end

    assign prod_w  = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign acc_sum = ACC_W'(acc_reg) + ACC_W'(prod_reg);
    assign fed_new = LW'(acc_sum >> ALPHA_W);
    assign oth_new = LW'(prod_reg >> ALPHA_W);

    // word capture and multiply pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_cnt_reg <= '0;
            clear_reg   <= 1'b0;
        end
        else if (in_take)
        begin
            mul_cnt_reg <= '0;
            clear_reg   <= (command == CMD_CLEAR);
        end
        else if (state_reg == ST_MUL)
        begin
            mul_cnt_reg <= mul_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            fed_bull_reg <= bias_pos;
            feed_reg     <= feed_w;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_w;
            if (mul_cnt_reg == 2'd1)
                acc_reg <= prod_reg;
        end
    end

    // divider operands
    assign bull_ge  = (bull_level_reg >= bear_level_reg);
    assign div_sum  = {1'b0, bull_level_reg} + {1'b0, bear_level_reg};
    assign div_diff = bull_ge ? (bull_level_reg - bear_level_reg)
                              : (bear_level_reg - bull_level_reg);
    assign sum_zero = (bull_level_reg == '0) && (bear_level_reg == '0);

    depi_divider #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_diff),
        .den   (div_sum),
        .stat  (div_stat),
        .quot  (quot)
    );

    // index, detection and counter updates
    always_comb
    begin
        if (sum_zero)
            idx_new = '0;
        else if (bull_ge)
            idx_new = quot[QUOT_W-1] ? INDEX_MAX : quot;
        else
            idx_new = ~quot + 1'b1;
        idx_mag     = idx_new[INDEX_W-1] ? (~idx_new + 1'b1) : idx_new;
        gate        = (CMP_W'(sample_cnt_reg) >= CMP_W'(warmup_reg));
        flip_now    = gate && seeded_reg && (last_index_reg[INDEX_W-1] != idx_new[INDEX_W-1]);
        extreme_now = gate && (idx_mag > {1'b0, extreme_reg});

        flip_cnt_next    = flip_cnt_reg;
        extreme_cnt_next = extreme_cnt_reg;
        sample_cnt_next  = (sample_cnt_reg == '1) ? sample_cnt_reg : sample_cnt_reg + 1'b1;
        if (flip_now && (flip_cnt_reg != '1))
            flip_cnt_next = flip_cnt_reg + 1'b1;
        if (extreme_now && (extreme_cnt_reg != '1))
            extreme_cnt_next = extreme_cnt_reg + 1'b1;
    end

    // averages, index history and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bull_level_reg  <= '0;
            bear_level_reg  <= '0;
            last_index_reg  <= '0;
            seeded_reg      <= 1'b0;
            flip_cnt_reg    <= '0;
            extreme_cnt_reg <= '0;
            sample_cnt_reg  <= '0;
        end
        else if (finish_go)
        begin
            if (clear_reg)
            begin
                bull_level_reg  <= '0;
                bear_level_reg  <= '0;
                last_index_reg  <= '0;
                seeded_reg      <= 1'b0;
                flip_cnt_reg    <= '0;
                extreme_cnt_reg <= '0;
                sample_cnt_reg  <= '0;
            end
            else
            begin
                last_index_reg  <= idx_new;
                seeded_reg      <= 1'b1;
                flip_cnt_reg    <= flip_cnt_next;
                extreme_cnt_reg <= extreme_cnt_next;
                sample_cnt_reg  <= sample_cnt_next;
            end
        end
        else if (state_reg == ST_MUL)
        begin
            if (mul_cnt_reg == 2'd2)
            begin
                if (fed_bull_reg)
                    bull_level_reg <= fed_new;
                else
                    bear_level_reg <= fed_new;
            end
            else if (mul_cnt_reg == MUL_LAST)
            begin
                if (fed_bull_reg)
                    bear_level_reg <= oth_new;
                else
                    bull_level_reg <= oth_new;
            end
        end
    end

    // result word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish_go)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            if (clear_reg)
            begin
                index_out_reg       <= '0;
                prev_out_reg        <= '0;
                flip_out_reg        <= 1'b0;
                extreme_out_reg     <= 1'b0;
                bull_out_reg        <= '0;
                bear_out_reg        <= '0;
                flip_out_cnt_reg    <= '0;
                extreme_out_cnt_reg <= '0;
                sample_out_cnt_reg  <= '0;
            end
            else
            begin
                index_out_reg       <= idx_new;
                prev_out_reg        <= last_index_reg;
                flip_out_reg        <= flip_now;
                extreme_out_reg     <= extreme_now;
                bull_out_reg        <= bull_level_reg;
                bear_out_reg        <= bear_level_reg;
                flip_out_cnt_reg    <= flip_cnt_next;
                extreme_out_cnt_reg <= extreme_cnt_next;
                sample_out_cnt_reg  <= sample_cnt_next;
            end
        end
    end

    assign polarity_index = index_out_reg;
    assign previous_index = prev_out_reg;
    assign flip_event     = flip_out_reg;
    assign extreme_event  = extreme_out_reg;
    assign bull_average   = bull_out_reg;
    assign bear_average   = bear_out_reg;
    assign flip_total     = flip_out_cnt_reg;
    assign extreme_total  = extreme_out_cnt_reg;
    assign sample_total   = sample_out_cnt_reg;

    `ASSERT_IMPLIES(a_bull_bound, clk, rst_n, 1'b1, bull_level_reg <= LEVEL_ONE)
    `ASSERT_IMPLIES(a_bear_bound, clk, rst_n, 1'b1, bear_level_reg <= LEVEL_ONE)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_take, state_reg != ST_IDLE)
    `ASSERT_IMPLIES(a_idle_div, clk, rst_n, state_reg == ST_IDLE, !div_stat.busy && !div_stat.done)
    `ASSERT_IMPLIES(a_seeded_count, clk, rst_n, 1'b1, (sample_cnt_reg != '0) == seeded_reg)

endmodule

FILE: test/tb_dual_ema_polarity_index_top.sv
// self-checking testbench of the dual moving average polarity index top level
// depends on depi_pkg and dual_ema_polarity_index_top; scoreboard predicts every result word
module tb_dual_ema_polarity_index_top;
    timeunit 1ns;
    timeprecision 1ps;

    import depi_pkg::*;

    localparam int LW = LEVEL_WIDTH_DEF;
    localparam int CW = COUNT_WIDTH_DEF;

    localparam logic [CW-1:0] COUNT_MAX   = '1;
    localparam int            CYCLE_LIMIT = 600000;
    localparam int            DRAIN_GAP   = 4;
    localparam int            TAIL_GAP    = 40;
    localparam int            PHASE_WORDS = 172;

    typedef struct packed {
        bit                        cmd;
        logic signed [INDEX_W-1:0] smp;
    } bias_word_t;

    typedef struct packed {
        logic signed [INDEX_W-1:0] index_now;
        logic signed [INDEX_W-1:0] index_prev;
        bit                        flip;
        bit                        extreme;
        logic [LW-1:0]             bull;
        logic [LW-1:0]             bear;
        logic [CW-1:0]             flips;
        logic [CW-1:0]             extremes;
        logic [CW-1:0]             samples;
    } index_word_t;

    // block ports
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [ALPHA_W-1:0]          cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        command = CMD_RECORD;
    logic signed [INDEX_W-1:0]   bias = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [INDEX_W-1:0]   polarity_index;
    logic signed [INDEX_W-1:0]   previous_index;
    logic                        flip_event;
    logic                        extreme_event;
    logic [LW-1:0]               bull_average;
    logic [LW-1:0]               bear_average;
    logic [CW-1:0]               flip_total;
    logic [CW-1:0]               extreme_total;
    logic [CW-1:0]               sample_total;

    // predictor copy of the registers and the state
    logic [ALPHA_W-1:0]          alpha;
    logic [ALPHA_W-1:0]          warmup_gate;
    logic [EXTREME_W-1:0]        extreme_thr;
    logic [LW-1:0]               bull_lvl;
    logic [LW-1:0]               bear_lvl;
    logic signed [INDEX_W-1:0]   last_idx;
    bit                          seeded;
    logic [CW-1:0]               flip_cnt;
    logic [CW-1:0]               extreme_cnt;
    logic [CW-1:0]               sample_cnt;

    bias_word_t  bias_words_pending[$];
    index_word_t index_words_due[$];
    int          words_queued = 0;
    int          words_taken = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle_pct = 27;
    int          recv_idle_pct = 84;

    dual_ema_polarity_index_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .bias           (bias),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .polarity_index (polarity_index),
        .previous_index (previous_index),
        .flip_event     (flip_event),
        .extreme_event  (extreme_event),
        .bull_average   (bull_average),
        .bear_average   (bear_average),
        .flip_total     (flip_total),
        .extreme_total  (extreme_total),
        .sample_total   (sample_total)
    );

    always #2 clk = ~clk;

    // one moving average step, truncated to the level width
    function automatic logic [LW-1:0] ema_step(input logic [LW-1:0] lvl,
                                               input longint unsigned feed);
        longint unsigned l;
        longint unsigned a;
        longint unsigned acc;
        l = lvl;
        a = alpha;
        acc = l * (64'd65536 - a) + feed * a;
        return LW'(acc >> 16);
    endfunction

    // apply one input word to the predicted state and return its result word
    function automatic index_word_t advance_polarity(input bit cmd,
                                                     input logic signed [INDEX_W-1:0] smp);
        index_word_t     w;
        longint unsigned mag;
        longint unsigned total;
        longint unsigned spread;
        longint unsigned quot;
        longint          idx_mag;
        logic signed [INDEX_W-1:0] idx;
        logic signed [INDEX_W-1:0] prev;
        w = '0;
        if (cmd == CMD_CLEAR)
        begin
            bull_lvl = '0;
            bear_lvl = '0;
            last_idx = '0;
            seeded = 1'b0;
            flip_cnt = '0;
            extreme_cnt = '0;
            sample_cnt = '0;
            return w;
        end
        mag = (smp < 0) ? -longint'(smp) : longint'(smp);
        // positive feeds bull, zero and negative feed bear
        if (smp > 0)
        begin
            bull_lvl = ema_step(bull_lvl, mag << 8);
            bear_lvl = ema_step(bear_lvl, 0);
        end
        else
        begin
            bull_lvl = ema_step(bull_lvl, 0);
            bear_lvl = ema_step(bear_lvl, mag << 8);
        end
        // normalized difference in q1.15
        total = longint'(bull_lvl) + longint'(bear_lvl);
        if (total == 0)
        begin
            idx = '0;
        end
        else
        begin
            spread = (bull_lvl >= bear_lvl) ? bull_lvl - bear_lvl : bear_lvl - bull_lvl;
            quot = (spread << 15) / total;
            if (bull_lvl >= bear_lvl)
            begin
                if (quot > 32767) quot = 32767;
                idx = INDEX_W'(quot);
            end
            else
            begin
                if (quot > 32768) quot = 32768;
                idx = INDEX_W'(-longint'(quot));
            end
        end
        prev = last_idx;
        // detection only after warm-up
        if (sample_cnt >= warmup_gate)
        begin
            if (seeded && ((prev >= 0) != (idx >= 0)))
            begin
                w.flip = 1'b1;
                if (flip_cnt != COUNT_MAX) flip_cnt++;
            end
            idx_mag = (idx < 0) ? -longint'(idx) : longint'(idx);
            if (idx_mag > extreme_thr)
            begin
                w.extreme = 1'b1;
                if (extreme_cnt != COUNT_MAX) extreme_cnt++;
            end
        end
        last_idx = idx;
        seeded = 1'b1;
        if (sample_cnt != COUNT_MAX) sample_cnt++;
        w.index_now = idx;
        w.index_prev = prev;
        w.bull = bull_lvl;
        w.bear = bear_lvl;
        w.flips = flip_cnt;
        w.extremes = extreme_cnt;
        w.samples = sample_cnt;
        return w;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // driver: present pending words, predict each one as it is taken
    always @(posedge clk)
    begin : driver
        bias_word_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                index_words_due.push_back(advance_polarity(command, bias));
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (bias_words_pending.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = bias_words_pending.pop_front();
                    command <= nxt.cmd;
                    bias <= nxt.smp;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each taken result word with the oldest prediction
    always @(posedge clk)
    begin : monitor
        index_word_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (index_words_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, index %0d",
                             $time, polarity_index);
                end
                else
                begin
                    want = index_words_due.pop_front();
                    check_field("polarity_index", $signed(want.index_now), polarity_index);
                    check_field("previous_index", $signed(want.index_prev), previous_index);
                    check_field("flip_event", want.flip, flip_event);
                    check_field("extreme_event", want.extreme, extreme_event);
                    check_field("bull_average", want.bull, bull_average);
                    check_field("bear_average", want.bear, bear_average);
                    check_field("flip_total", want.flips, flip_total);
                    check_field("extreme_total", want.extremes, extreme_total);
                    check_field("sample_total", want.samples, sample_total);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_dual_ema_polarity_index_top: done, errors");
            $finish;
        end
    end

    task automatic push_word(input bit cmd, input logic signed [INDEX_W-1:0] smp);
        bias_word_t w;
        w.cmd = cmd;
        w.smp = smp;
        bias_words_pending.push_back(w);
        words_queued++;
    endtask

    // wait until every word is taken and answered, then let the block settle
    task automatic drain;
        do @(negedge clk);
        while (words_taken != words_queued || index_words_due.size() != 0);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        unique case (idx)
            REG_SMOOTHING: alpha = val;
            REG_WARMUP:    warmup_gate = val;
            REG_EXTREME:   extreme_thr = val[EXTREME_W-1:0];
            default: ;
        endcase
    endtask

    // runs of same-sign samples with random content, some noise and rare clears
    task automatic queue_random(input int n);
        int run_left;
        bit run_bear;
        int pick;
        int mag;
        logic signed [INDEX_W-1:0] smp;
        run_left = 0;
        run_bear = 1'b0;
        repeat (n)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(12, 1);
                run_bear = $urandom_range(1);
            end
            run_left--;
            pick = $urandom_range(99);
            smp = INDEX_W'($urandom);
            if (pick < 2)
            begin
                push_word(CMD_CLEAR, smp);
            end
            else if (pick < 12)
            begin
                push_word(CMD_RECORD, smp);
            end
            else if (pick < 20)
            begin
                if (!run_bear) smp = 16'sh7FFF;
                else smp = (pick < 16) ? 16'sh8000 : 16'sh0000;
                push_word(CMD_RECORD, smp);
            end
            else
            begin
                mag = $urandom_range(32767, 1);
                push_word(CMD_RECORD, run_bear ? INDEX_W'(-mag) : INDEX_W'(mag));
            end
        end
    endtask

    task automatic run_phase(input logic [ALPHA_W-1:0] sf, input logic [ALPHA_W-1:0] wu,
                             input logic [ALPHA_W-1:0] xl, input int spct, input int rpct);
        drain();
        write_reg(REG_SMOOTHING, sf);
        write_reg(REG_WARMUP, wu);
        write_reg(REG_EXTREME, xl);
        send_idle_pct = spct;
        recv_idle_pct = rpct;
        queue_random(PHASE_WORDS);
    endtask

    initial
    begin
        alpha = SMOOTH_RST;
        warmup_gate = WARMUP_RST;
        extreme_thr = EXTREME_RST;
        bull_lvl = '0;
        bear_lvl = '0;
        last_idx = '0;
        seeded = 1'b0;
        flip_cnt = '0;
        extreme_cnt = '0;
        sample_cnt = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset values of the registers, field extremes, clear
        push_word(CMD_RECORD, 16'sh0000);
        push_word(CMD_RECORD, 16'sh7FFF);
        push_word(CMD_RECORD, 16'sh8000);
        push_word(CMD_RECORD, -16'sd1);
        push_word(CMD_RECORD, 16'sd1);
        push_word(CMD_RECORD, 16'sh5555);
        push_word(CMD_CLEAR, 16'sh7FFF);

        // full weight, no warm-up: first sample after clear, flips, extremes
        drain();
        write_reg(REG_SMOOTHING, 16'hFFFF);
        write_reg(REG_WARMUP, 16'd0);
        write_reg(REG_EXTREME, 16'h7FFF);
        push_word(CMD_RECORD, 16'sh8000);
        push_word(CMD_RECORD, 16'sh7FFF);
        push_word(CMD_RECORD, 16'sh8000);
        push_word(CMD_RECORD, 16'sh0000);
        push_word(CMD_RECORD, 16'sd1);
        push_word(CMD_RECORD, -16'sd1);
        push_word(CMD_RECORD, 16'sh7FFF);
        push_word(CMD_RECORD, 16'sh7FFF);

        // detection held off by a long warm-up, zero threshold
        drain();
        write_reg(REG_EXTREME, 16'h0000);
        write_reg(REG_WARMUP, 16'hFFFF);
        push_word(CMD_RECORD, 16'sh7FFF);
        push_word(CMD_RECORD, 16'sh8000);
        push_word(CMD_CLEAR, 16'sh0000);

        // zero weight keeps the averages where they are
        drain();
        write_reg(REG_SMOOTHING, 16'h0000);
        push_word(CMD_RECORD, 16'sh7FFF);
        push_word(CMD_RECORD, 16'sh8000);

        // random phases over several register settings and idle mixes
        run_phase(16'd6554, 16'd10, 16'd26214, 27, 84);
        run_phase(16'd0, 16'hFFFF, 16'd0, 27, 84);
        run_phase(16'hFFFF, 16'd0, 16'h7FFF, 84, 27);
        run_phase(ALPHA_W'($urandom), ALPHA_W'($urandom_range(20)), ALPHA_W'($urandom),
                  84, 27);
        run_phase(16'h8000, 16'd1, 16'h4000, 0, 0);
        run_phase(ALPHA_W'($urandom_range(65535, 1)), ALPHA_W'($urandom_range(5)),
                  ALPHA_W'($urandom), 0, 0);

        drain();
        repeat (TAIL_GAP) @(posedge clk);
        if (mismatches == 0 && index_words_due.size() == 0)
        begin
            $display("tb_dual_ema_polarity_index_top: done, clean");
        end
        else
        begin
            $display("tb_dual_ema_polarity_index_top: done, errors");
        end
        $finish;
    end

endmodule
